FILE: src/vec3_arith_unit_macros.svh
// Assertion macros shared by the vector ALU modules.
`ifndef VEC3_ARITH_UNIT_MACROS_SVH
`define VEC3_ARITH_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define VAU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vau: assertion failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define VAU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vau: assertion failed");

`endif

FILE: src/vau_pkg.sv
// Types, constants and operation codes of the three-component vector ALU.
package vau_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	localparam int PW        = 2 * DW;
	localparam int CW        = PW + 2;
	localparam int NMUL      = 6;

	localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_SCALE = 3'd2,
		OP_DOT   = 3'd3,
		OP_CROSS = 3'd4
	} op_t;

	// stage 1: multiplier operands plus exact add/sub results
	typedef struct packed {
		logic [NMUL-1:0][DW-1:0] ma;
		logic [NMUL-1:0][DW-1:0] mb;
		logic [2:0][DW:0]        lin;
		logic                    use_lin;
		logic                    dot;
	} s1_t;

	// stage 2: full-width products
	typedef struct packed {
		logic [NMUL-1:0][PW-1:0] p;
		logic [2:0][DW:0]        lin;
		logic                    use_lin;
		logic                    dot;
	} s2_t;

	// stage 3: exact combined values before shift
	typedef struct packed {
		logic [2:0][CW-1:0] c;
		logic               use_lin;
		logic               dot;
	} s3_t;

endpackage

FILE: src/vau_ifs.sv
// Valid/ready channel interfaces for the vector ALU request and result.
interface vau_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        operation;
	logic signed [31:0] a_x;
	logic signed [31:0] a_y;
	logic signed [31:0] a_z;
	logic signed [31:0] b_x;
	logic signed [31:0] b_y;
	logic signed [31:0] b_z;
	logic signed [31:0] scale_factor;

	modport source (output valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
		input ready);
	modport sink (input valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
		output ready);
endinterface

interface vau_rsp_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] r_x;
	logic signed [31:0] r_y;
	logic signed [31:0] r_z;
	logic              saturated;

	modport source (output valid, r_x, r_y, r_z, saturated, input ready);
	modport sink (input valid, r_x, r_y, r_z, saturated, output ready);
endinterface

FILE: src/vau_front.sv
// Stage 1: operation decode, multiplier operand routing, exact add/subtract.
module vau_front (
	input  logic            clk,
	input  logic            arst_n,
	vau_req_if.sink         req,
	output vau_pkg::s1_t    s1,
	output logic            v_s1,
	input  logic            rdy_nxt
);

	vau_pkg::s1_t                  d;
	logic [2:0][vau_pkg::DW-1:0]   a;
	logic [2:0][vau_pkg::DW-1:0]   b;
	logic                          rdy;
	logic signed [vau_pkg::DW:0]   ea;
	logic signed [vau_pkg::DW:0]   eb;

	assign a   = {req.a_z, req.a_y, req.a_x};
	assign b   = {req.b_z, req.b_y, req.b_x};
	assign rdy = !v_s1 || rdy_nxt;
	assign req.ready = rdy;

	always_comb begin
		d = '0;
		ea = '0;
		eb = '0;
		unique case (vau_pkg::op_t'(req.operation))
			vau_pkg::OP_ADD: begin
				d.use_lin = 1'b1;
				for (int i = 0; i < 3; i++) begin
					ea = {a[i][vau_pkg::DW-1], a[i]};
					eb = {b[i][vau_pkg::DW-1], b[i]};
					d.lin[i] = ea + eb;
				end
			end
			vau_pkg::OP_SUB: begin
				d.use_lin = 1'b1;
				for (int i = 0; i < 3; i++) begin
					ea = {a[i][vau_pkg::DW-1], a[i]};
					eb = {b[i][vau_pkg::DW-1], b[i]};
					d.lin[i] = ea - eb;
				end
			end
			vau_pkg::OP_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					d.ma[2*i] = a[i];
					d.mb[2*i] = req.scale_factor;
				end
			end
			vau_pkg::OP_DOT: begin
				d.dot = 1'b1;
				for (int i = 0; i < 3; i++) begin
					d.ma[2*i] = a[i];
					d.mb[2*i] = b[i];
				end
			end
			vau_pkg::OP_CROSS: begin
				// even lane minus odd lane gives each cross component
				d.ma[0] = a[1]; d.mb[0] = b[2];
				d.ma[1] = a[2]; d.mb[1] = b[1];
				d.ma[2] = a[2]; d.mb[2] = b[0];
				d.ma[3] = a[0]; d.mb[3] = b[2];
				d.ma[4] = a[0]; d.mb[4] = b[1];
				d.ma[5] = a[1]; d.mb[5] = b[0];
			end
			default: begin
				// unused code: zero result, no clamp
				d.use_lin = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && req.valid) begin
			s1 <= d;
		end
	end

endmodule

FILE: src/vau_mult.sv
// Stages 2-3: six 32x32 products; dot sum, lane differences or add/sub.
`include "vec3_arith_unit_macros.svh"

module vau_mult (
	input  logic            clk,
	input  logic            arst_n,
	input  vau_pkg::s1_t    s1,
	input  logic            v_s1,
	output logic            rdy_s1,
	output vau_pkg::s3_t    s3,
	output logic            v_s3,
	input  logic            rdy_nxt
);

	vau_pkg::s2_t                 s2;
	logic                         v_s2;
	logic                         rdy_s2;
	logic                         rdy_s3;
	logic [vau_pkg::NMUL-1:0][vau_pkg::PW-1:0] prod;
	vau_pkg::s3_t                 c_d;
	logic signed [vau_pkg::CW-1:0] pe [vau_pkg::NMUL];
	logic signed [vau_pkg::CW-1:0] le [3];

	assign rdy_s3 = !v_s3 || rdy_nxt;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = rdy_s2;

	always_comb begin
		for (int k = 0; k < vau_pkg::NMUL; k++) begin
			prod[k] = $signed(s1.ma[k]) * $signed(s1.mb[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			s2.p       <= prod;
			s2.lin     <= s1.lin;
			s2.use_lin <= s1.use_lin;
			s2.dot     <= s1.dot;
		end
	end

	always_comb begin
		for (int k = 0; k < vau_pkg::NMUL; k++) begin
			pe[k] = vau_pkg::CW'($signed(s2.p[k]));
		end
		for (int i = 0; i < 3; i++) begin
			le[i] = vau_pkg::CW'($signed(s2.lin[i]));
		end
		c_d = '0;
		c_d.use_lin = s2.use_lin;
		c_d.dot     = s2.dot;
		if (s2.use_lin) begin
			for (int i = 0; i < 3; i++) c_d.c[i] = le[i];
		end else if (s2.dot) begin
			c_d.c[0] = pe[0] + pe[2] + pe[4];
		end else begin
			// odd lanes are zero for scale
			for (int i = 0; i < 3; i++) c_d.c[i] = pe[2*i] - pe[2*i+1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			s3 <= c_d;
		end
	end

	`VAU_ASSERT_NXT(a_s2_hold, v_s2 && !rdy_s3, v_s2 && $stable(s2))

endmodule

FILE: src/vau_sat.sv
// Stage 4: fraction shift, clamp to 32 bits, result register.
`include "vec3_arith_unit_macros.svh"

module vau_sat (
	input  logic            clk,
	input  logic            arst_n,
	input  vau_pkg::s3_t    s3,
	input  logic            v_s3,
	output logic            rdy_s3,
	vau_rsp_if.source       rsp
);

	logic                          rdy;
	logic                          v_s4;
	logic signed [vau_pkg::CW-1:0] v [3];
	logic [2:0][vau_pkg::DW-1:0]   r_d;
	logic [2:0]                    clamp;
	logic [2:0][vau_pkg::DW-1:0]   r_s4;
	logic                          sat_s4;
	logic                          any_rail;

	assign rdy    = !v_s4 || rsp.ready;
	assign rdy_s3 = rdy;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v[i] = s3.use_lin ? $signed(s3.c[i]) : ($signed(s3.c[i]) >>> vau_pkg::FRAC_BITS);
			// fits when all bits from the sign of a 32-bit word upward agree
			clamp[i] = !((&v[i][vau_pkg::CW-1:vau_pkg::DW-1]) ||
				!(|v[i][vau_pkg::CW-1:vau_pkg::DW-1]));
			if (!clamp[i]) r_d[i] = v[i][vau_pkg::DW-1:0];
			else if (v[i][vau_pkg::CW-1]) r_d[i] = vau_pkg::SAT_MIN;
			else r_d[i] = vau_pkg::SAT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && v_s3) begin
			r_s4   <= r_d;
			sat_s4 <= |clamp;
		end
	end

	assign rsp.valid     = v_s4;
	assign rsp.r_x       = r_s4[0];
	assign rsp.r_y       = r_s4[1];
	assign rsp.r_z       = r_s4[2];
	assign rsp.saturated = sat_s4;

	// some component sits on a rail
	assign any_rail = r_s4[0] == vau_pkg::SAT_MAX || r_s4[0] == vau_pkg::SAT_MIN ||
		r_s4[1] == vau_pkg::SAT_MAX || r_s4[1] == vau_pkg::SAT_MIN ||
		r_s4[2] == vau_pkg::SAT_MAX || r_s4[2] == vau_pkg::SAT_MIN;

	`VAU_ASSERT_IMP(a_dot_yz_zero, v_s3 && s3.dot, s3.c[1] == '0 && s3.c[2] == '0)
	`VAU_ASSERT_IMP(a_sat_extreme, v_s4 && sat_s4, any_rail)

endmodule

FILE: src/vec3_arith_unit.sv
// Top level of the three-component fixed-point vector ALU.
//
//  channel | dir | fields                                              | handshake
//  --------+-----+-----------------------------------------------------+-----------
//  req     | in  | operation, a_x..a_z, b_x..b_z, scale_factor (Q16.16) | valid/ready
//  rsp     | out | r_x, r_y, r_z (Q16.16), saturated                    | valid/ready
//
//  Throughput: one beat per cycle while rsp is not stalled; four register
//  stages (operand routing, multiply, combine, shift/clamp), the last of which
//  drives rsp valid and the result fields straight from its registers.
//  The six 32x32 multipliers in stage 2 set the clock period.
//  Reset (arst_n low) clears every stage valid bit; data registers keep junk.
//  A stall on rsp holds the result register; each stage with a bubble still
//  fills, so req.ready drops only when all four stages hold a beat.
`include "vec3_arith_unit_macros.svh"

module vec3_arith_unit (
	input  logic      clk,
	input  logic      arst_n,
	vau_req_if.sink   req,
	vau_rsp_if.source rsp
);

	vau_pkg::s1_t s1;
	vau_pkg::s3_t s3;
	logic         v_s1;
	logic         v_s3;
	logic         rdy_s1;
	logic         rdy_s3;

	// stage 1: decode and operand routing
	vau_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.s1      (s1),
		.v_s1    (v_s1),
		.rdy_nxt (rdy_s1)
	);

	// stages 2 and 3: products and their sums/differences
	vau_mult u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.s1      (s1),
		.v_s1    (v_s1),
		.rdy_s1  (rdy_s1),
		.s3      (s3),
		.v_s3    (v_s3),
		.rdy_nxt (rdy_s3)
	);

	// stage 4: shift, clamp, result register
	vau_sat u_sat (
		.clk    (clk),
		.arst_n (arst_n),
		.s3     (s3),
		.v_s3   (v_s3),
		.rdy_s3 (rdy_s3),
		.rsp    (rsp)
	);

	// back-pressure reaches req only with every stage full and rsp stalled
	`VAU_ASSERT_IMP(a_full_when_blocked, !req.ready, v_s1 && v_s3 && rsp.valid && !rsp.ready)

endmodule

FILE: bench/vec3_arith_unit_test.sv
// Self-checking bench for vec3_arith_unit: directed table, then random vector traffic.
`default_nettype none

module vec3_arith_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Operation codes, taken from the package.
	localparam vau_pkg::op_t OP_ADD   = vau_pkg::OP_ADD;
	localparam vau_pkg::op_t OP_SUB   = vau_pkg::OP_SUB;
	localparam vau_pkg::op_t OP_SCALE = vau_pkg::OP_SCALE;
	localparam vau_pkg::op_t OP_DOT   = vau_pkg::OP_DOT;
	localparam vau_pkg::op_t OP_CROSS = vau_pkg::OP_CROSS;

	// Opcodes that the block must treat as no-ops (all zero, flag low).
	localparam logic [2:0] OP_RSVD_5 = 3'd5;
	localparam logic [2:0] OP_RSVD_6 = 3'd6;
	localparam logic [2:0] OP_RSVD_7 = 3'd7;

	// Handy Q16.16 values for the directed table.
	localparam logic signed [31:0] Q_ZERO  = 32'sh0000_0000;
	localparam logic signed [31:0] Q_HALF  = 32'sh0000_8000;
	localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
	localparam logic signed [31:0] Q_TWO   = 32'sh0002_0000;
	localparam logic signed [31:0] Q_THREE = 32'sh0003_0000;
	localparam logic signed [31:0] NEG_LSB = 32'shFFFF_FFFF;
	localparam logic signed [31:0] Q_MAX   = vau_pkg::SAT_MAX;
	localparam logic signed [31:0] Q_MIN   = vau_pkg::SAT_MIN;

	// Clamp bounds, sign-extended to the width of the exact sums.
	localparam logic signed [127:0] WIDE_MAX = $signed(vau_pkg::SAT_MAX);
	localparam logic signed [127:0] WIDE_MIN = $signed(vau_pkg::SAT_MIN);

	localparam int DIR_ROWS        = 24;
	localparam int RAND_PER_PHASE  = 376;  // three phases, ~1150 beats with the table
	localparam int HOLD_CYCLES     = 60;   // long rsp back-pressure, fills all four stages
	localparam int DRAIN_LIMIT     = 5000;
	localparam int SETTLE_CYCLES   = 8;    // four-stage pipe, plus margin

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] scale_factor;
	} vec_req_t;

	typedef struct packed {
		logic signed [31:0] r_x;
		logic signed [31:0] r_y;
		logic signed [31:0] r_z;
		logic               saturated;
	} vec_rsp_t;

	// One directed beat. When has_want is low the predictor supplies the answer.
	typedef struct packed {
		vec_req_t stim;
		logic     has_want;
		vec_rsp_t want;
	} dir_row_t;

	localparam vec_rsp_t UNTYPED = '0;

	logic clk;
	logic arst_n;

	vau_req_if req_ch ();
	vau_rsp_if rsp_ch ();

	vec3_arith_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	vec_rsp_t pending_results[$];
	int       mismatch_count = 0;
	int       tx_idle_pct    = 0;
	int       rx_idle_pct    = 0;
	bit       hold_pending   = 1'b0;

	// Directed beats: field extremes, every opcode, saturation on both rails,
	// truncation toward minus infinity, exact sums before the shift, ignored
	// operands, zero y/z on dot, and the unused opcodes.
	dir_row_t dir_tab [DIR_ROWS] = '{
		// add: plain, with -1 lsb crossing into the fraction
		'{'{OP_ADD, Q_ONE, Q_TWO, NEG_LSB, Q_TWO, Q_ONE, Q_ONE, NEG_LSB}, 1'b1,
			'{Q_THREE, Q_THREE, 32'sh0000_FFFF, 1'b0}},
		// add: overflow on both rails
		'{'{OP_ADD, Q_MAX, Q_MIN, Q_ZERO, 32'sd1, NEG_LSB, Q_ZERO, Q_ZERO}, 1'b1,
			'{Q_MAX, Q_MIN, Q_ZERO, 1'b1}},
		'{'{OP_ADD, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN}, 1'b1,
			'{NEG_LSB, NEG_LSB, Q_MAX, 1'b1}},
		// subtract: 0 - MIN must clamp
		'{'{OP_SUB, Q_MIN, Q_MAX, Q_ZERO, 32'sd1, NEG_LSB, Q_MIN, Q_MAX}, 1'b1,
			'{Q_MIN, Q_MAX, Q_MAX, 1'b1}},
		'{'{OP_SUB, Q_THREE, Q_ONE, Q_ZERO, Q_ONE, Q_THREE, Q_ZERO, Q_ZERO}, 1'b1,
			'{Q_TWO, 32'shFFFE_0000, Q_ZERO, 1'b0}},
		// scale by 1.0 is identity; b is junk and ignored
		'{'{OP_SCALE, Q_MAX, Q_MIN, 32'sh0001_2345, NEG_LSB, NEG_LSB, NEG_LSB, Q_ONE},
			1'b1, '{Q_MAX, Q_MIN, 32'sh0001_2345, 1'b0}},
		// scale: MIN*MIN and MAX*MIN clamp
		'{'{OP_SCALE, Q_MIN, Q_MIN, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN}, 1'b1,
			'{Q_MAX, Q_MAX, Q_MIN, 1'b1}},
		// scale by one lsb: -1 lsb stays -1 (floor, not toward zero)
		'{'{OP_SCALE, NEG_LSB, Q_TWO, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, 32'sd1}, 1'b1,
			'{NEG_LSB, 32'sd2, 32'sd1, 1'b0}},
		'{'{OP_SCALE, Q_MAX, Q_MIN, NEG_LSB, Q_MAX, Q_MIN, Q_MAX, Q_ZERO}, 1'b1,
			'{Q_ZERO, Q_ZERO, Q_ZERO, 1'b0}},
		// dot: unit vectors, y/z forced to zero, scale_factor ignored
		'{'{OP_DOT, Q_ONE, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_MAX}, 1'b1,
			'{Q_ONE, Q_ZERO, Q_ZERO, 1'b0}},
		'{'{OP_DOT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b1,
			'{Q_MAX, Q_ZERO, Q_ZERO, 1'b1}},
		// dot: huge products cancel exactly before the shift
		'{'{OP_DOT, Q_MIN, Q_MIN, Q_ZERO, Q_MIN, Q_MAX, Q_ZERO, Q_ZERO}, 1'b1,
			'{Q_HALF, Q_ZERO, Q_ZERO, 1'b0}},
		'{'{OP_DOT, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN, NEG_LSB}, 1'b0, UNTYPED},
		'{'{OP_DOT, NEG_LSB, NEG_LSB, NEG_LSB, Q_ONE, Q_ONE, Q_ONE, Q_ZERO}, 1'b0,
			UNTYPED},
		// cross: x cross y = z
		'{'{OP_CROSS, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_MIN}, 1'b1,
			'{Q_ZERO, Q_ZERO, Q_ONE, 1'b0}},
		'{'{OP_CROSS, Q_ZERO, Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN, Q_ZERO}, 1'b1,
			'{Q_MAX, Q_ZERO, Q_ZERO, 1'b1}},
		'{'{OP_CROSS, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_ZERO}, 1'b0, UNTYPED},
		'{'{OP_CROSS, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX}, 1'b0, UNTYPED},
		// unused opcodes: everything zero whatever the operands
		'{'{OP_RSVD_5, NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB},
			1'b1, '{Q_ZERO, Q_ZERO, Q_ZERO, 1'b0}},
		'{'{OP_RSVD_6, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b1,
			'{Q_ZERO, Q_ZERO, Q_ZERO, 1'b0}},
		'{'{OP_RSVD_7, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX}, 1'b1,
			'{Q_ZERO, Q_ZERO, Q_ZERO, 1'b0}},
		// all-ones / all-max operands through the predictor
		'{'{OP_ADD, NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB}, 1'b0,
			UNTYPED},
		'{'{OP_SCALE, NEG_LSB, Q_MAX, Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, NEG_LSB}, 1'b0,
			UNTYPED},
		'{'{OP_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_ZERO}, 1'b0, UNTYPED}
	};

	// Shift the exact value right (floor), then clamp to 32-bit signed.
	function automatic logic signed [31:0] clamp_q16(input logic signed [127:0] v,
		input int sh, inout bit sat);
		logic signed [127:0] s;
		s = v >>> sh;
		if (s > WIDE_MAX) begin
			sat = 1'b1;
			return vau_pkg::SAT_MAX;
		end
		if (s < WIDE_MIN) begin
			sat = 1'b1;
			return vau_pkg::SAT_MIN;
		end
		return s[31:0];
	endfunction

	// Expected result of one request beat; all sums kept exact at 128 bits.
	function automatic vec_rsp_t predict_vec(input vec_req_t q);
		logic signed [127:0] ax, ay, az, bx, by, bz, f;
		bit       sat;
		vec_rsp_t r;
		ax  = q.a_x;
		ay  = q.a_y;
		az  = q.a_z;
		bx  = q.b_x;
		by  = q.b_y;
		bz  = q.b_z;
		f   = q.scale_factor;
		sat = 1'b0;
		r   = '0;
		case (q.operation)
			OP_ADD: begin
				r.r_x = clamp_q16(ax + bx, 0, sat);
				r.r_y = clamp_q16(ay + by, 0, sat);
				r.r_z = clamp_q16(az + bz, 0, sat);
			end
			OP_SUB: begin
				r.r_x = clamp_q16(ax - bx, 0, sat);
				r.r_y = clamp_q16(ay - by, 0, sat);
				r.r_z = clamp_q16(az - bz, 0, sat);
			end
			OP_SCALE: begin
				r.r_x = clamp_q16(ax * f, vau_pkg::FRAC_BITS, sat);
				r.r_y = clamp_q16(ay * f, vau_pkg::FRAC_BITS, sat);
				r.r_z = clamp_q16(az * f, vau_pkg::FRAC_BITS, sat);
			end
			OP_DOT: begin
				r.r_x = clamp_q16(ax * bx + ay * by + az * bz, vau_pkg::FRAC_BITS, sat);
			end
			OP_CROSS: begin
				r.r_x = clamp_q16(ay * bz - az * by, vau_pkg::FRAC_BITS, sat);
				r.r_y = clamp_q16(az * bx - ax * bz, vau_pkg::FRAC_BITS, sat);
				r.r_z = clamp_q16(ax * by - ay * bx, vau_pkg::FRAC_BITS, sat);
			end
			default: ;
		endcase
		r.saturated = sat;
		return r;
	endfunction

	// Mostly modest magnitudes so products land in range; some full-width
	// noise and rail values so the clamps and every bit still get exercised.
	function automatic logic signed [31:0] random_q16();
		logic signed [31:0] w;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: w = Q_MAX;
					1: w = Q_MIN;
					2: w = Q_ZERO;
					default: w = NEG_LSB;
				endcase
			end
			1, 2, 3: w = $urandom();
			default: w = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
		endcase
		return w;
	endfunction

	function automatic vec_req_t random_vec();
		vec_req_t v;
		int       pick;
		pick = $urandom_range(0, 19);
		// unused opcodes only now and then
		v.operation    = (pick < 18) ? 3'(pick % 5) : 3'($urandom_range(5, 7));
		v.a_x          = random_q16();
		v.a_y          = random_q16();
		v.a_z          = random_q16();
		v.b_x          = random_q16();
		v.b_y          = random_q16();
		v.b_z          = random_q16();
		v.scale_factor = random_q16();
		return v;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// Offer one beat on req, idling first at random. Holds valid until the
	// beat is taken, then queues what the result must look like.
	task automatic send_vec(input vec_req_t item, input vec_rsp_t want);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.operation    <= item.operation;
		req_ch.a_x          <= item.a_x;
		req_ch.a_y          <= item.a_y;
		req_ch.a_z          <= item.a_z;
		req_ch.b_x          <= item.b_x;
		req_ch.b_y          <= item.b_y;
		req_ch.b_z          <= item.b_z;
		req_ch.scale_factor <= item.scale_factor;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_results.push_back(want);
	endtask

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: random back-pressure, plus one long hold on request from the
	// stimulus so the four stages fill and req.ready has to drop.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_pending = 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Result checker: every rsp beat against the oldest queued expectation.
	always @(posedge clk) begin
		vec_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result beat x=%h y=%h z=%h sat=%b",
					rsp_ch.r_x, rsp_ch.r_y, rsp_ch.r_z, rsp_ch.saturated));
			end else begin
				want = pending_results.pop_front();
				check_field("r_x", rsp_ch.r_x, want.r_x);
				check_field("r_y", rsp_ch.r_y, want.r_y);
				check_field("r_z", rsp_ch.r_z, want.r_z);
				check_field("saturated", 32'(rsp_ch.saturated), 32'(want.saturated));
			end
		end
	end

	// Stimulus: reset, directed table, three random phases, drain, verdict.
	initial begin
		vec_req_t item;
		int       waited;

		arst_n               = 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.operation    <= OP_ADD;
		req_ch.a_x          <= '0;
		req_ch.a_y          <= '0;
		req_ch.a_z          <= '0;
		req_ch.b_x          <= '0;
		req_ch.b_y          <= '0;
		req_ch.b_z          <= '0;
		req_ch.scale_factor <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase 1 idling pattern also covers the table
		tx_idle_pct = 38;
		rx_idle_pct = 65;
		for (int i = 0; i < DIR_ROWS; i++) begin
			send_vec(dir_tab[i].stim,
				dir_tab[i].has_want ? dir_tab[i].want : predict_vec(dir_tab[i].stim));
		end

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 38;
					rx_idle_pct = 65;
				end
				1: begin
					tx_idle_pct = 65;
					rx_idle_pct = 38;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				// full-rate phase: stop the receiver for a while mid-stream
				if (ph == 2 && n == 100)
					hold_pending = 1'b1;
				item = random_vec();
				send_vec(item, predict_vec(item));
			end
		end
		req_ch.valid <= 1'b0;

		// let the pipe empty, then give stray beats a chance to show up
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));

		if (mismatch_count == 0) begin
			$display("vec3_arith_unit verification clean");
		end else begin
			$display("vec3_arith_unit verification failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("vec3_arith_unit verification failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
+incdir+src
src/vau_pkg.sv
src/vau_ifs.sv
src/vau_front.sv
src/vau_mult.sv
src/vau_sat.sv
src/vec3_arith_unit.sv
bench/vec3_arith_unit_test.sv
